/* src/hex_mesh_neighbour_index_macros.svh */
// Assertion macros shared by the hexagonal-mesh neighbour lookup checkers.
// Each macro expects clk and rst_n to be visible in the scope of its use.
`ifndef HEX_MESH_NEIGHBOUR_INDEX_MACROS_SVH
`define HEX_MESH_NEIGHBOUR_INDEX_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HMNI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HMNI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hmni_pkg.sv */
// Shared types, constants and helper functions of the hexagonal-mesh neighbour lookup.
// No dependencies; every module and interface of the block imports this package.
package hmni_pkg;

  localparam int IDX_W       = 16;
  localparam int DIR_W       = 3;
  localparam int SIZE_W      = 9;
  localparam int COUNT_W     = 17;
  localparam int COORD_W     = 8;
  localparam int MODE_W      = 2;
  localparam int CFG_W       = COUNT_W;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = IDX_W + SIZE_W;
  localparam int SUM_W       = PROD_W + 1;

  // Long division: quotient bits retired per pipeline stage.
  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = IDX_W / DIV_BITS;

  // Fixed hexagon-shaped board.
  localparam int BOARD_CHIPS   = 48;
  localparam int BOARD_IDX_W   = $clog2(BOARD_CHIPS);
  localparam int BOARD_COLS    = 8;
  localparam int BOARD_ROWS    = 8;
  localparam int BOARD_COORD_W = 3;
  localparam int BOARD_SUM_W   = BOARD_COORD_W + 2;

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(256);
  localparam logic [IDX_W-1:0]  IDX_MAX  = '1;

  // Topology modes; the remaining code behaves as the open rectangle.
  localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TORUS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOARD = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd3;

  // Link directions.
  localparam logic [DIR_W-1:0] DIR_E  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NE = 3'd1;
  localparam logic [DIR_W-1:0] DIR_N  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_W_ = 3'd3;
  localparam logic [DIR_W-1:0] DIR_SW = 3'd4;
  localparam logic [DIR_W-1:0] DIR_S  = 3'd5;

  // Board columns: first chip index, lowest and highest y of each column.
  localparam logic [BOARD_IDX_W-1:0] BOARD_COL_START [BOARD_COLS] =
    '{6'd0, 6'd4, 6'd9, 6'd15, 6'd22, 6'd30, 6'd37, 6'd43};
  localparam logic [BOARD_COORD_W-1:0] BOARD_COL_YLO [BOARD_COLS] =
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [BOARD_COORD_W-1:0] BOARD_COL_YHI [BOARD_COLS] =
    '{3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7};

  typedef struct packed {
    logic xp;
    logic xn;
    logic yp;
    logic yn;
  } step_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rem;
    logic [IDX_W-1:0]  qd;
  } div_state_t;

  typedef struct packed {
    logic [BOARD_COORD_W-1:0] x;
    logic [BOARD_COORD_W-1:0] y;
  } board_pos_t;

  typedef struct packed {
    logic                   found;
    logic [BOARD_IDX_W-1:0] idx;
  } board_hit_t;

  // Context that travels with a request down the pipeline.
  typedef struct packed {
    step_t                    step;
    logic                     dir_ok;
    logic                     in_range;
    logic                     board_mode;
    logic                     torus;
    logic                     board_found;
    logic [BOARD_IDX_W-1:0]   board_nbr;
    logic [BOARD_COORD_W-1:0] board_x;
    logic [BOARD_COORD_W-1:0] board_y;
    logic [IDX_W-1:0]         grid_x;
    logic [COORD_W-1:0]       grid_y;
  } ctx_t;

  typedef struct packed {
    logic [IDX_W-1:0]   neighbour_index;
    logic               has_neighbour;
    logic [COORD_W-1:0] chip_x;
    logic [COORD_W-1:0] chip_y;
    logic               index_in_range;
  } rsp_t;

  function automatic step_t dir_step(logic [DIR_W-1:0] d);
    step_t s;
    s = '0;
    unique case (d)
      DIR_E:   s.xp = 1'b1;
      DIR_NE:  begin
        s.xp = 1'b1;
        s.yp = 1'b1;
      end
      DIR_N:   s.yp = 1'b1;
      DIR_W_:  s.xn = 1'b1;
      DIR_SW:  begin
        s.xn = 1'b1;
        s.yn = 1'b1;
      end
      DIR_S:   s.yn = 1'b1;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_MIN;
    end else if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // DIV_BITS steps of restoring division; quotient bits shift in from the right.
  function automatic div_state_t div_steps(div_state_t s, logic [SIZE_W-1:0] d);
    div_state_t t;
    logic [SIZE_W:0] trial;
    t = s;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {t.rem, t.qd[IDX_W-1]};
      t.qd  = {t.qd[IDX_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        trial   = trial - {1'b0, d};
        t.qd[0] = 1'b1;
      end
      t.rem = trial[SIZE_W-1:0];
    end
    return t;
  endfunction

  // Coordinates of a board chip; the caller guarantees idx < BOARD_CHIPS.
  function automatic board_pos_t board_pos(logic [BOARD_IDX_W-1:0] idx);
    board_pos_t p;
    logic [BOARD_IDX_W-1:0] ofs;
    p   = '0;
    ofs = '0;
    for (int c = 0; c < BOARD_COLS; c++) begin
      if (idx >= BOARD_COL_START[c]) begin
        p.x = BOARD_COORD_W'(c);
        ofs = idx - BOARD_COL_START[c];
        p.y = BOARD_COL_YLO[c] + ofs[BOARD_COORD_W-1:0];
      end
    end
    return p;
  endfunction

  // Inverse lookup: which board chip sits at (nx, ny), if any.
  function automatic board_hit_t board_find(logic signed [BOARD_SUM_W-1:0] nx,
                                            logic signed [BOARD_SUM_W-1:0] ny);
    board_hit_t h;
    logic [BOARD_COORD_W-1:0] cx;
    logic [BOARD_COORD_W-1:0] cy;
    h  = '0;
    cx = nx[BOARD_COORD_W-1:0];
    cy = ny[BOARD_COORD_W-1:0];
    if (nx >= 0 && nx < BOARD_COLS && ny >= 0 && ny < BOARD_ROWS) begin
      if (cy >= BOARD_COL_YLO[cx] && cy <= BOARD_COL_YHI[cx]) begin
        h.found = 1'b1;
        h.idx   = BOARD_COL_START[cx] + BOARD_IDX_W'(cy - BOARD_COL_YLO[cx]);
      end
    end
    return h;
  endfunction

endpackage

/* src/hmni_ifs.sv */
// Valid/ready channel interfaces for the request and result sides of the lookup.
// Depends on hmni_pkg for the field widths.
interface hmni_req_if import hmni_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   chip_index;
  logic [DIR_W-1:0]   direction;

  modport source (output valid, output chip_index, output direction, input ready);
  modport sink   (input valid, input chip_index, input direction, output ready);
endinterface

interface hmni_rsp_if import hmni_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   neighbour_index;
  logic               has_neighbour;
  logic [COORD_W-1:0] chip_x;
  logic [COORD_W-1:0] chip_y;
  logic               index_in_range;

  modport source (output valid, output neighbour_index, output has_neighbour,
                  output chip_x, output chip_y, output index_in_range, input ready);
  modport sink   (input valid, input neighbour_index, input has_neighbour,
                  input chip_x, input chip_y, input index_in_range, output ready);
endinterface

/* src/hmni_div_pipe.sv */
// Pipelined unsigned long division of a chip index by a grid size, with context sideband.
// Depends on hmni_pkg (div_steps, ctx_t, widths).
module hmni_div_pipe import hmni_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  in_dividend,
  input  ctx_t              in_ctx,
  input  logic [SIZE_W-1:0] divisor,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_quot,
  output logic [SIZE_W-1:0] out_rem,
  output ctx_t              out_ctx
);

  logic [DIV_STAGES-1:0] v_r;
  div_state_t            st_r   [DIV_STAGES];
  ctx_t                  ctx_r  [DIV_STAGES];

  logic [DIV_STAGES-1:0] v_in;
  div_state_t            st_in  [DIV_STAGES];
  div_state_t            st_nxt [DIV_STAGES];
  ctx_t                  ctx_in [DIV_STAGES];
  logic [DIV_STAGES:0]   rdy;

  always_comb begin
    v_in[0]   = in_valid;
    st_in[0]  = '{rem: '0, qd: in_dividend};
    ctx_in[0] = in_ctx;
    for (int s = 1; s < DIV_STAGES; s++) begin
      v_in[s]   = v_r[s-1];
      st_in[s]  = st_r[s-1];
      ctx_in[s] = ctx_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      st_nxt[s] = div_steps(st_in[s], divisor);
    end
    // A stage takes new data when it is empty or its successor moves on.
    rdy[DIV_STAGES] = out_ready;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_in[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rdy[s]) begin
        st_r[s]  <= st_nxt[s];
        ctx_r[s] <= ctx_in[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[DIV_STAGES-1];
  assign out_quot  = st_r[DIV_STAGES-1].qd;
  assign out_rem   = st_r[DIV_STAGES-1].rem;
  assign out_ctx   = ctx_r[DIV_STAGES-1];

endmodule

/* src/hmni_nbr_calc.sv */
// Grid neighbour step, index multiply and final range check with the result register.
// Depends on hmni_pkg (ctx_t, rsp_t, widths).
module hmni_nbr_calc import hmni_pkg::*; #(
  parameter int COORD_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctx_t               in_ctx,
  input  logic [SIZE_W-1:0]  in_xmod,
  input  logic [SIZE_W-1:0]  grid_w,
  input  logic [SIZE_W-1:0]  grid_h,
  input  logic [COUNT_W-1:0] chip_count,
  output logic               out_valid,
  input  logic               out_ready,
  output rsp_t               out_rsp
);

  // Step stage.
  logic               n_v_r;
  logic [IDX_W-1:0]   n_nx_r;
  logic [COORD_W-1:0] n_ny_r;
  logic               n_ok_r;
  ctx_t               n_ctx_r;
  // Multiply stage.
  logic               m_v_r;
  logic [PROD_W-1:0]  m_prod_r;
  logic [COORD_W-1:0] m_ny_r;
  logic               m_ok_r;
  ctx_t               m_ctx_r;
  // Result register.
  logic                  o_v_r;
  logic [IDX_W-1:0]      o_nbr_r;
  logic                  o_has_r;
  logic [COORD_BITS-1:0] o_x_r;
  logic [COORD_BITS-1:0] o_y_r;
  logic                  o_inr_r;

  logic n_rdy, m_rdy, o_rdy;

  logic [IDX_W-1:0]   x;
  logic [COORD_W-1:0] y;
  logic [IDX_W:0]     x_inc;
  logic [SIZE_W-1:0]  xm_inc;
  logic [SIZE_W-1:0]  y_inc;
  logic [IDX_W-1:0]   n_nx_nxt;
  logic [COORD_W-1:0] n_ny_nxt;
  logic               step_ok;
  logic [PROD_W-1:0]  m_prod_nxt;
  logic [SUM_W-1:0]   idx;
  logic               grid_found;
  logic               o_has_nxt;
  logic [IDX_W-1:0]   o_nbr_nxt;
  logic [COORD_W-1:0] o_x_nxt;
  logic [COORD_W-1:0] o_y_nxt;

  assign o_rdy    = !o_v_r || out_ready;
  assign m_rdy    = !m_v_r || o_rdy;
  assign n_rdy    = !n_v_r || m_rdy;
  assign in_ready = n_rdy;

  always_comb begin
    x        = in_ctx.grid_x;
    y        = in_ctx.grid_y;
    x_inc    = {1'b0, x} + 1'b1;
    xm_inc   = in_xmod + 1'b1;
    y_inc    = {1'b0, y} + 1'b1;
    n_nx_nxt = x;
    n_ny_nxt = y;
    step_ok  = 1'b1;
    if (in_ctx.torus) begin
      if (in_ctx.step.xp) begin
        n_nx_nxt = (xm_inc == grid_w) ? '0 : IDX_W'(xm_inc);
      end else if (in_ctx.step.xn) begin
        n_nx_nxt = (in_xmod == '0) ? IDX_W'(grid_w - 1'b1) : IDX_W'(in_xmod - 1'b1);
      end
      if (in_ctx.step.yp) begin
        n_ny_nxt = (y_inc == grid_h) ? '0 : y_inc[COORD_W-1:0];
      end else if (in_ctx.step.yn) begin
        n_ny_nxt = (y == '0) ? COORD_W'(grid_h - 1'b1) : y - 1'b1;
      end
    end else begin
      if (in_ctx.step.xp) begin
        if (x_inc < (IDX_W + 1)'(grid_w)) begin
          n_nx_nxt = x_inc[IDX_W-1:0];
        end else begin
          step_ok = 1'b0;
        end
      end else if (in_ctx.step.xn) begin
        if (x != '0) begin
          n_nx_nxt = x - 1'b1;
        end else begin
          step_ok = 1'b0;
        end
      end
      if (in_ctx.step.yp) begin
        if (y_inc < grid_h) begin
          n_ny_nxt = y_inc[COORD_W-1:0];
        end else begin
          step_ok = 1'b0;
        end
      end else if (in_ctx.step.yn) begin
        if (y != '0) begin
          n_ny_nxt = y - 1'b1;
        end else begin
          step_ok = 1'b0;
        end
      end
    end
  end

  assign m_prod_nxt = PROD_W'(n_nx_r) * PROD_W'(grid_h);

  always_comb begin
    idx        = {1'b0, m_prod_r} + SUM_W'(m_ny_r);
    grid_found = m_ok_r && (idx < SUM_W'(chip_count)) && (idx <= SUM_W'(IDX_MAX));
    o_has_nxt  = m_ctx_r.board_mode ? m_ctx_r.board_found : grid_found;
    o_nbr_nxt  = '0;
    if (o_has_nxt) begin
      o_nbr_nxt = m_ctx_r.board_mode ? IDX_W'(m_ctx_r.board_nbr) : idx[IDX_W-1:0];
    end
    o_x_nxt = '0;
    o_y_nxt = '0;
    if (m_ctx_r.in_range) begin
      o_x_nxt = m_ctx_r.board_mode ? COORD_W'(m_ctx_r.board_x) : m_ctx_r.grid_x[COORD_W-1:0];
      o_y_nxt = m_ctx_r.board_mode ? COORD_W'(m_ctx_r.board_y) : m_ctx_r.grid_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (n_rdy) begin
        n_v_r <= in_valid;
      end
      if (m_rdy) begin
        m_v_r <= n_v_r;
      end
      if (o_rdy) begin
        o_v_r <= m_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n_rdy) begin
      n_nx_r  <= n_nx_nxt;
      n_ny_r  <= n_ny_nxt;
      n_ok_r  <= !in_ctx.board_mode && in_ctx.in_range && in_ctx.dir_ok && step_ok;
      n_ctx_r <= in_ctx;
    end
    if (m_rdy) begin
      m_prod_r <= m_prod_nxt;
      m_ny_r   <= n_ny_r;
      m_ok_r   <= n_ok_r;
      m_ctx_r  <= n_ctx_r;
    end
    if (o_rdy) begin
      o_nbr_r <= o_nbr_nxt;
      o_has_r <= o_has_nxt;
      o_x_r   <= o_x_nxt[COORD_BITS-1:0];
      o_y_r   <= o_y_nxt[COORD_BITS-1:0];
      o_inr_r <= m_ctx_r.in_range;
    end
  end

  assign out_valid               = o_v_r;
  assign out_rsp.neighbour_index = o_nbr_r;
  assign out_rsp.has_neighbour   = o_has_r;
  assign out_rsp.chip_x          = COORD_W'(o_x_r);
  assign out_rsp.chip_y          = COORD_W'(o_y_r);
  assign out_rsp.index_in_range  = o_inr_r;

endmodule

/* src/hex_mesh_neighbour_index.sv */
// Top level of the hexagonal-mesh neighbour lookup: configuration, entry stage, pipeline.
// Depends on hmni_pkg, hmni_ifs, hmni_div_pipe and hmni_nbr_calc.
//
//   Channel   Direction  Handshake          Contents
//   in_req    sink       valid / ready      chip_index, direction
//   out_rsp   source     valid / ready      neighbour_index, has_neighbour, chip_x,
//                                           chip_y, index_in_range
//   cfg_*     sink       cfg_we only        cfg_index selects the register, cfg_wdata
//
// Every request passes 12 register stages: one entry stage, two 4-stage long
// dividers (x and y from the chip index, then x modulo the width) and three stages
// for the step, the index multiply and the range check. One request is accepted
// per cycle while the result side is not stalled; each stage holds only while it is
// full and its successor is stalled, so bubbles are squeezed out under back-pressure.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults (open rectangle, 8 by 8 grid, 64 chips).
module hex_mesh_neighbour_index import hmni_pkg::*; #(
  parameter int COORD_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hmni_req_if.sink             in_req,
  hmni_rsp_if.source           out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers. Grid sizes are stored already clamped to 1..256,
  // which gives the same answers as clamping them at every lookup.
  logic [MODE_W-1:0]  mode_r;
  logic [SIZE_W-1:0]  width_r;
  logic [SIZE_W-1:0]  height_r;
  logic [COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OPEN;
      width_r  <= SIZE_W'(8);
      height_r <= SIZE_W'(8);
      count_r  <= COUNT_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_WIDTH:  width_r  <= clamp_size(cfg_wdata[SIZE_W-1:0]);
        CFG_HEIGHT: height_r <= clamp_size(cfg_wdata[SIZE_W-1:0]);
        CFG_COUNT:  count_r  <= cfg_wdata[COUNT_W-1:0];
      endcase
    end
  end

  // Entry stage. It decodes the direction, checks the chip index against the
  // chips in use, and in board mode resolves the whole lookup from the fixed
  // column tables; the grid modes continue through the dividers.
  logic             ent_v_r;
  logic [IDX_W-1:0] ent_chip_r;
  ctx_t             ent_ctx_r;
  ctx_t             ent_ctx_nxt;
  logic             ent_rdy;

  step_t                          step;
  logic                           board;
  logic                           in_range;
  logic                           dir_ok;
  board_pos_t                     bpos;
  board_hit_t                     bhit;
  logic signed [BOARD_SUM_W-1:0]  bnx;
  logic signed [BOARD_SUM_W-1:0]  bny;

  always_comb begin
    step     = dir_step(in_req.direction);
    dir_ok   = (in_req.direction <= DIR_S);
    board    = (mode_r == MODE_BOARD);
    in_range = board ? (in_req.chip_index < IDX_W'(BOARD_CHIPS))
                     : (COUNT_W'(in_req.chip_index) < count_r);
    bpos     = board_pos(in_req.chip_index[BOARD_IDX_W-1:0]);
    bnx      = $signed(BOARD_SUM_W'(bpos.x)) + $signed(BOARD_SUM_W'(step.xp))
             - $signed(BOARD_SUM_W'(step.xn));
    bny      = $signed(BOARD_SUM_W'(bpos.y)) + $signed(BOARD_SUM_W'(step.yp))
             - $signed(BOARD_SUM_W'(step.yn));
    bhit     = board_find(bnx, bny);

    ent_ctx_nxt             = '0;
    ent_ctx_nxt.step        = step;
    ent_ctx_nxt.dir_ok      = dir_ok;
    ent_ctx_nxt.in_range    = in_range;
    ent_ctx_nxt.board_mode  = board;
    ent_ctx_nxt.torus       = (mode_r == MODE_TORUS);
    ent_ctx_nxt.board_found = board && in_range && dir_ok && bhit.found;
    ent_ctx_nxt.board_nbr   = bhit.idx;
    ent_ctx_nxt.board_x     = in_range ? bpos.x : '0;
    ent_ctx_nxt.board_y     = in_range ? bpos.y : '0;
  end

  logic               d1_in_ready;
  logic               d1_v;
  logic [IDX_W-1:0]   d1_quot;
  logic [SIZE_W-1:0]  d1_rem;
  ctx_t               d1_ctx;
  ctx_t               d2_ctx_in;
  logic               d2_in_ready;
  logic               d2_v;
  logic [SIZE_W-1:0]  d2_rem;
  ctx_t               d2_ctx;
  logic               nc_in_ready;
  rsp_t               rsp;

  assign ent_rdy      = !ent_v_r || d1_in_ready;
  assign in_req.ready = ent_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
    end else if (ent_rdy) begin
      ent_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_rdy) begin
      ent_chip_r <= in_req.chip_index;
      ent_ctx_r  <= ent_ctx_nxt;
    end
  end

  // x = chip / height, y = chip % height.
  hmni_div_pipe u_div_xy (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (ent_v_r),
    .in_ready    (d1_in_ready),
    .in_dividend (ent_chip_r),
    .in_ctx      (ent_ctx_r),
    .divisor     (height_r),
    .out_valid   (d1_v),
    .out_ready   (d2_in_ready),
    .out_quot    (d1_quot),
    .out_rem     (d1_rem),
    .out_ctx     (d1_ctx)
  );

  always_comb begin
    d2_ctx_in        = d1_ctx;
    d2_ctx_in.grid_x = d1_quot;
    d2_ctx_in.grid_y = d1_rem[COORD_W-1:0];
  end

  // x modulo width, needed when a chip lies past the last column in torus mode.
  hmni_div_pipe u_div_xmod (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (d1_v),
    .in_ready    (d2_in_ready),
    .in_dividend (d1_quot),
    .in_ctx      (d2_ctx_in),
    .divisor     (width_r),
    .out_valid   (d2_v),
    .out_ready   (nc_in_ready),
    .out_quot    (),
    .out_rem     (d2_rem),
    .out_ctx     (d2_ctx)
  );

  hmni_nbr_calc #(
    .COORD_BITS (COORD_BITS)
  ) u_nbr (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d2_v),
    .in_ready   (nc_in_ready),
    .in_ctx     (d2_ctx),
    .in_xmod    (d2_rem),
    .grid_w     (width_r),
    .grid_h     (height_r),
    .chip_count (count_r),
    .out_valid  (out_rsp.valid),
    .out_ready  (out_rsp.ready),
    .out_rsp    (rsp)
  );

  assign out_rsp.neighbour_index = rsp.neighbour_index;
  assign out_rsp.has_neighbour   = rsp.has_neighbour;
  assign out_rsp.chip_x          = rsp.chip_x;
  assign out_rsp.chip_y          = rsp.chip_y;
  assign out_rsp.index_in_range  = rsp.index_in_range;

endmodule

/* src/hmni_assert_chk.sv */
// Port-level checker for the hexagonal-mesh neighbour lookup, bound to the top level.
// Depends on hmni_pkg and the assertion macros header.
`include "hex_mesh_neighbour_index_macros.svh"

module hmni_assert_chk import hmni_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [IDX_W-1:0]   out_neighbour_index,
  input logic               out_has_neighbour,
  input logic [COORD_W-1:0] out_chip_x,
  input logic [COORD_W-1:0] out_chip_y,
  input logic               out_index_in_range
);

  // A result for a chip that is not in use carries nothing but zeros.
  `HMNI_ASSERT_SAME(a_unused_chip_zero, out_valid && !out_index_in_range, !out_has_neighbour && out_neighbour_index == '0 && out_chip_x == '0 && out_chip_y == '0, "unused chip gave a nonzero result")

  // A neighbour can only exist for a chip that is in use.
  `HMNI_ASSERT_SAME(a_nbr_needs_range, out_valid && out_has_neighbour, out_index_in_range, "neighbour reported for a chip out of range")

  // Without a neighbour the index reads as zero.
  `HMNI_ASSERT_SAME(a_no_nbr_zero_index, out_valid && !out_has_neighbour, out_neighbour_index == '0, "neighbour index set without a neighbour")

  // A stalled result stays put.
  `HMNI_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_neighbour_index) && $stable(out_has_neighbour) && $stable(out_chip_x) && $stable(out_chip_y) && $stable(out_index_in_range), "result changed while stalled")

endmodule

bind hex_mesh_neighbour_index hmni_assert_chk u_hmni_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_rsp.valid),
  .out_ready           (out_rsp.ready),
  .out_neighbour_index (out_rsp.neighbour_index),
  .out_has_neighbour   (out_rsp.has_neighbour),
  .out_chip_x          (out_rsp.chip_x),
  .out_chip_y          (out_rsp.chip_y),
  .out_index_in_range  (out_rsp.index_in_range)
);
